### design/tcw_pkg.sv
package tcw_pkg;

  localparam int OFF_W = 20;

  typedef logic [OFF_W-1:0] off_t;
  typedef logic [1:0]       bank_t;

  typedef struct packed {
    bank_t bank;
    off_t  off;
  } addr_t;

  localparam logic [5:0]  HIDE_LINE   = 6'd32;
  localparam logic [4:0]  HEIGHT_16   = 5'd16;
  localparam logic [4:0]  HEIGHT_19   = 5'd19;
  localparam logic [4:0]  HEIGHT_24   = 5'd24;
  localparam logic [7:0]  COLS_P128   = 8'd85;
  localparam logic [7:0]  PITCH_128   = 8'd128;
  localparam logic [7:0]  PITCH_160   = 8'd160;
  localparam off_t        BANK_SPAN   = 20'h10000;
  localparam off_t        BANK2_BASE  = 20'h20000;
  localparam bank_t       BANK_TOP    = 2'd2;
  localparam logic [7:0]  PAT_FULL    = 8'hff;
  localparam logic [7:0]  PAT_LO      = 8'h0f;
  localparam logic [7:0]  PAT_HI      = 8'hf0;

  localparam logic [1:0]  CFG_COLUMNS = 2'd0;
  localparam logic [1:0]  CFG_HEIGHT  = 2'd1;
  localparam logic [1:0]  CFG_BANK_EN = 2'd2;

  // cursor shape tables, raw lines 0..7
  function automatic logic [5:0] map_line(input logic [5:0] v, input logic [4:0] ch);
    logic [5:0] r;
    r = v;
    if (v < 6'd8) begin
      case (ch)
        HEIGHT_24: begin
          case (v[2:0])
            3'd0: r = 6'd0;
            3'd1: r = 6'd3;
            3'd2: r = 6'd8;
            3'd3: r = 6'd12;
            3'd4: r = 6'd15;
            3'd5: r = 6'd18;
            3'd6: r = 6'd21;
            default: r = 6'd23;
          endcase
        end
        HEIGHT_19: begin
          case (v[2:0])
            3'd0: r = 6'd0;
            3'd1: r = 6'd3;
            3'd2: r = 6'd6;
            3'd3: r = 6'd9;
            3'd4: r = 6'd11;
            3'd5: r = 6'd13;
            3'd6: r = 6'd16;
            default: r = 6'd18;
          endcase
        end
        HEIGHT_16: begin
          case (v[2:0])
            3'd0: r = 6'd0;
            3'd1: r = 6'd3;
            3'd2: r = 6'd5;
            3'd3: r = 6'd7;
            3'd4: r = 6'd9;
            3'd5: r = 6'd11;
            3'd6: r = 6'd13;
            default: r = 6'd15;
          endcase
        end
        default: r = v;
      endcase
    end
    return r;
  endfunction

  function automatic addr_t bank_step(input addr_t a);
    addr_t r;
    r = a;
    if (a.off >= BANK_SPAN) begin
      if (a.bank < BANK_TOP) r.bank = a.bank + 2'd1;
      r.off = a.off - BANK_SPAN;
    end
    return r;
  endfunction

  // advance from one scanline's first byte to the next scanline's first byte
  function automatic addr_t line_step(input addr_t a, input logic [2:0] n,
                                      input logic [7:0] pitch, input logic bank_en);
    addr_t r;
    r = a;
    for (int k = 1; k < 4; k++) begin
      if (3'(k) < n) begin
        r.off = r.off + off_t'(1);
        r = bank_step(r);
      end
    end
    r.off = r.off - off_t'(n - 3'd1) + off_t'(pitch);
    if (bank_en) r = bank_step(r);
    return r;
  endfunction

endpackage

### design/text_cursor_write_generator.sv
// Text cursor write generator.
// A request is taken on the edge where start is high and busy is low; its
// fields are in_cell_column, in_pixel_row, in_cursor_top, in_cursor_bottom
// and in_double_wide. A hidden or inverted cursor is taken but yields
// nothing and busy stays low. Otherwise the block emits one beat per
// cursor scanline on the out_ ports, each marked by out_valid for one
// cycle; out_last flags the final scanline. The receiver cannot stall.
// Timing: the row start offset is formed by an 8-step shift-add multiplier,
// then a setup state places it in a bank, then the scanline stepper gives
// one beat per cycle. Busy stays high from the accepting edge until the
// last beat shows; it gives L beats, L being the scanline count
// (1..64). A new request may be taken in the cycle that shows the last beat.
// Configuration (cfg_we, cfg_index, cfg_wdata) takes effect at once; write
// it only while idle (not enforced): 0 text columns, 1 character height,
// 2 bank enable. Reset (rst_n low, synchronous) returns to idle with 80
// columns, height 16 and banking off; a request in flight is dropped.
module text_cursor_write_generator
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_cell_column,
  input  logic [10:0] in_pixel_row,
  input  logic [5:0]  in_cursor_top,
  input  logic [5:0]  in_cursor_bottom,
  input  logic        in_double_wide,
  output logic        out_valid,
  output logic [1:0]  out_bank,
  output logic [15:0] out_offset,
  output logic [2:0]  out_byte_count,
  output logic [7:0]  out_first_byte,
  output logic [7:0]  out_last_byte,
  output logic        out_last
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MUL   = 2'd1;
  localparam logic [1:0] ST_SETUP = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [7:0] cols_r;
  logic [4:0] height_r;
  logic       bank_en_r;

  logic [1:0] state_r, state_nxt;
  logic [5:0] line_r, line_nxt;
  logic [5:0] bot_r, bot_nxt;
  logic [2:0] n_r, n_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] lastp_r, lastp_nxt;
  logic [8:0] colterm_r, colterm_nxt;
  addr_t      addr_r, addr_nxt;

  logic       ov_r, ov_nxt;
  logic [1:0] obank_r, obank_nxt;
  logic [15:0] ooff_r, ooff_nxt;
  logic [2:0] ocnt_r, ocnt_nxt;
  logic [7:0] ofirst_r, ofirst_nxt;
  logic [7:0] olast_pat_r, olast_pat_nxt;
  logic       olast_r, olast_nxt;

  logic       wide;
  logic [7:0] pitch;
  logic [5:0] mtop, mbot;
  logic       hidden, go;
  logic [11:0] mcand;
  logic       mul_done;
  off_t       prod;
  off_t       off0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r    <= 8'd80;
      height_r  <= HEIGHT_16;
      bank_en_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLUMNS: cols_r    <= cfg_wdata;
        CFG_HEIGHT:  height_r  <= cfg_wdata[4:0];
        CFG_BANK_EN: bank_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign wide   = (height_r == HEIGHT_24);
  assign pitch  = wide ? ((cols_r == COLS_P128) ? PITCH_128 : PITCH_160) : cols_r;
  assign mtop   = map_line(in_cursor_top, height_r);
  assign mbot   = map_line(in_cursor_bottom, height_r);
  assign hidden = (in_cursor_top == HIDE_LINE) || (in_cursor_top > in_cursor_bottom)
                  || (mtop > mbot);
  assign go     = start && !busy && !hidden;
  assign mcand  = 12'(in_pixel_row) + 12'(mtop);
  assign busy   = (state_r != ST_IDLE);
  assign off0   = prod + off_t'(colterm_r);

  tcw_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (go),
    .mcand  (mcand),
    .mplier (pitch),
    .done   (mul_done),
    .prod   (prod)
  );

  always_comb begin
    state_nxt     = state_r;
    line_nxt      = line_r;
    bot_nxt       = bot_r;
    n_nxt         = n_r;
    first_nxt     = first_r;
    lastp_nxt     = lastp_r;
    colterm_nxt   = colterm_r;
    addr_nxt      = addr_r;
    ov_nxt        = 1'b0;
    obank_nxt     = obank_r;
    ooff_nxt      = ooff_r;
    ocnt_nxt      = ocnt_r;
    ofirst_nxt    = ofirst_r;
    olast_pat_nxt = olast_pat_r;
    olast_nxt     = olast_r;
    case (state_r)
      ST_IDLE: begin
        if (go) begin
          state_nxt = ST_MUL;
          line_nxt  = mtop;
          bot_nxt   = mbot;
          if (wide) begin
            // 12-pixel cells: byte offset is 1.5 * column
            colterm_nxt = 9'(in_cell_column) + 9'(in_cell_column[7:1]);
            if (in_double_wide) begin
              n_nxt     = in_cell_column[0] ? 3'd4 : 3'd3;
              first_nxt = in_cell_column[0] ? PAT_LO : PAT_FULL;
              lastp_nxt = in_cell_column[0] ? PAT_HI : PAT_FULL;
            end else begin
              n_nxt     = 3'd2;
              first_nxt = in_cell_column[0] ? PAT_LO : PAT_FULL;
              lastp_nxt = in_cell_column[0] ? PAT_FULL : PAT_HI;
            end
          end else begin
            colterm_nxt = 9'(in_cell_column);
            n_nxt       = in_double_wide ? 3'd2 : 3'd1;
            first_nxt   = PAT_FULL;
            lastp_nxt   = PAT_FULL;
          end
        end
      end
      ST_MUL: begin
        if (mul_done) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        state_nxt     = ST_EMIT;
        addr_nxt.bank = 2'd0;
        addr_nxt.off  = off0;
        if (bank_en_r) begin
          if (off0 >= BANK2_BASE) begin
            addr_nxt.bank = 2'd2;
            addr_nxt.off  = off0 - BANK2_BASE;
          end else if (off0 >= BANK_SPAN) begin
            addr_nxt.bank = 2'd1;
            addr_nxt.off  = off0 - BANK_SPAN;
          end
        end
      end
      ST_EMIT: begin
        ov_nxt        = 1'b1;
        obank_nxt     = addr_r.bank;
        ooff_nxt      = addr_r.off[15:0];
        ocnt_nxt      = n_r;
        ofirst_nxt    = first_r;
        olast_pat_nxt = lastp_r;
        olast_nxt     = (line_r == bot_r);
        addr_nxt      = line_step(addr_r, n_r, pitch, bank_en_r);
        line_nxt      = line_r + 6'd1;
        if (line_r == bot_r) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    line_r      <= line_nxt;
    bot_r       <= bot_nxt;
    n_r         <= n_nxt;
    first_r     <= first_nxt;
    lastp_r     <= lastp_nxt;
    colterm_r   <= colterm_nxt;
    addr_r      <= addr_nxt;
    obank_r     <= obank_nxt;
    ooff_r      <= ooff_nxt;
    ocnt_r      <= ocnt_nxt;
    ofirst_r    <= ofirst_nxt;
    olast_pat_r <= olast_pat_nxt;
    olast_r     <= olast_nxt;
  end

  assign out_valid      = ov_r;
  assign out_bank       = obank_r;
  assign out_offset     = ooff_r;
  assign out_byte_count = ocnt_r;
  assign out_first_byte = ofirst_r;
  assign out_last_byte  = olast_pat_r;
  assign out_last       = olast_r;

  a_beat_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_EMIT))
    else $error("beat without emit state");

  a_line_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (line_r <= bot_r))
    else $error("scanline counter ran past bottom");

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_MUL))
    else $error("product ready outside multiply phase");

  a_bank_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (addr_r.bank != 2'd3))
    else $error("bank out of range");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("busy after final beat");

endmodule

### design/tcw_mul.sv
module tcw_mul
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [11:0] mcand,
  input  logic [7:0]  mplier,
  output logic        done,
  output off_t        prod
);

  logic       run_r, run_nxt;
  logic       done_r, done_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  off_t       acc_r, acc_nxt;
  off_t       mc_r, mc_nxt;
  logic [7:0] mp_r, mp_nxt;

  // one shift-add per cycle until the product is done
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = 3'd0;
      acc_nxt = '0;
      mc_nxt  = off_t'(mcand);
      mp_nxt  = mplier;
    end else if (run_r) begin
      if (mp_r[0]) acc_nxt = acc_r + mc_r;
      mc_nxt  = {mc_r[OFF_W-2:0], 1'b0};
      mp_nxt  = {1'b0, mp_r[7:1]};
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
